// ===== hdl/bmsi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmsi_pkg
// Shared types and codes for the banked mapper with scanline interrupt.
// ----------------------------------------------------------------------------
package bmsi_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRG_COUNT   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_RAM = 1'd1;

   localparam logic [2:0] CMD_PRG_READ     = 3'd0;
   localparam logic [2:0] CMD_REG_WRITE    = 3'd1;
   localparam logic [2:0] CMD_PATTERN_READ = 3'd2;
   localparam logic [2:0] CMD_SCANLINE     = 3'd3;
   localparam logic [2:0] CMD_IRQ_ACK      = 3'd4;

   localparam logic [7:0] PAT_PAIR_MASK = 8'hFE;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [18:0] mapped_address;
      logic        irq_pending;
      logic        mirror_horizontal;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic rebuild;
   } ctl_type;

   typedef struct packed {
      logic bank_write;
   } stat_type;

endpackage
`default_nettype wire

// ===== hdl/banked_mapper_with_scanline_irq_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// banked_mapper_with_scanline_irq_top
// Cartridge bank mapper with scanline interrupt counter.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Its result appears on
// rsp_word for exactly one cycle with rsp_strobe high, after the EXEC state
// and the strobe register; the receiver cannot stall it, so it must capture
// the word in that cycle. A word holds the block in the EXEC state, or also
// in the REBUILD state for a bank data write, which rebuilds the window
// tables in the datapath; busy can drop in the cycle the result is shown, so a
// new word may start then. Configuration writes take effect at once and are
// meant only while busy is low.
// ----------------------------------------------------------------------------
module banked_mapper_with_scanline_irq_top
   import bmsi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_word,
   output logic                        rsp_strobe,
   output rsp_type                     rsp_word,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   ctl_type  ctl;
   stat_type stat;

   bmsi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctl        (ctl),
      .stat       (stat)
   );

   bmsi_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_word       (req_word),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .ctl            (ctl),
      .stat           (stat),
      .rsp_word       (rsp_word)
   );

endmodule
`default_nettype wire

// ===== hdl/bmsi_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmsi_ctrl
// Sequencer: capture a word, execute it, rebuild window tables after a
// bank data write, and strobe the result.
// ----------------------------------------------------------------------------
module bmsi_ctrl
   import bmsi_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   output logic          rsp_strobe,
   output ctl_type       ctl,
   input  wire stat_type stat
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_EXEC    = 2'd1;
   localparam logic [1:0] ST_REBUILD = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   always_comb begin
      state_in    = state_ff;
      strobe_in   = 1'b0;
      ctl.load    = 1'b0;
      ctl.exec    = 1'b0;
      ctl.rebuild = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec  = 1'b1;
            strobe_in = 1'b1;
            state_in  = stat.bank_write ? ST_REBUILD : ST_IDLE;
         end
         ST_REBUILD: begin
            ctl.rebuild = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule
`default_nettype wire

// ===== hdl/bmsi_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmsi_dp
// Datapath: mapper registers, window tables, scanline counter and address
// translation.
// ----------------------------------------------------------------------------
module bmsi_dp
   import bmsi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire req_type                req_word,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   input  wire ctl_type                ctl,
   output stat_type                    stat,
   output rsp_type                     rsp_word
);

   localparam logic [1:0] RGN_BANK       = 2'd0;
   localparam logic [1:0] RGN_MIRROR     = 2'd1;
   localparam logic [1:0] RGN_IRQ_LATCH  = 2'd2;
   localparam logic [1:0] RGN_IRQ_ENABLE = 2'd3;

   req_type     req_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [5:0]  count_ff, count_in;
   logic        pat_ram_ff, pat_ram_in;
   logic [2:0]  target_ff, target_in;
   logic        swap_ff, swap_in;
   logic        invert_ff, invert_in;
   logic [7:0]  bank_data_ff [8];
   logic [7:0]  bank_data_in [8];
   logic [5:0]  prg_win_ff [4];
   logic [5:0]  prg_win_in [4];
   logic [7:0]  pat_win_ff [8];
   logic [7:0]  pat_win_in [8];
   logic        mirror_ff, mirror_in;
   logic [7:0]  reload_ff, reload_in;
   logic [7:0]  counter_ff, counter_in;
   logic        irq_en_ff, irq_en_in;
   logic        irq_flag_ff, irq_flag_in;
   logic [7:0]  low_set [4];
   logic [7:0]  high_set [4];
   logic [18:0] mapped;

   function automatic logic [5:0] second_last(input logic [5:0] count);
      return {count[4:0], 1'b0} - 6'd2;
   endfunction

   function automatic logic [5:0] last(input logic [5:0] count);
      return {count[4:0], 1'b0} - 6'd1;
   endfunction

   always_comb begin
      count_in    = count_ff;
      pat_ram_in  = pat_ram_ff;
      target_in   = target_ff;
      swap_in     = swap_ff;
      invert_in   = invert_ff;
      bank_data_in = bank_data_ff;
      prg_win_in  = prg_win_ff;
      pat_win_in  = pat_win_ff;
      mirror_in   = mirror_ff;
      reload_in   = reload_ff;
      counter_in  = counter_ff;
      irq_en_in   = irq_en_ff;
      irq_flag_in = irq_flag_ff;
      mapped      = '0;

      for (int i = 0; i < 4; i++) begin
         low_set[i]  = (i % 2 == 0) ? (bank_data_ff[i / 2] & PAT_PAIR_MASK)
                                    : (bank_data_ff[i / 2] | 8'd1);
         high_set[i] = bank_data_ff[i + 2];
      end

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PRG_COUNT: begin
               count_in      = csr_write_data;
               prg_win_in[3] = last(csr_write_data);
               if (swap_ff) begin
                  prg_win_in[0] = second_last(csr_write_data);
               end else begin
                  prg_win_in[2] = second_last(csr_write_data);
               end
            end
            CSR_PATTERN_RAM: begin
               pat_ram_in = csr_write_data[0];
            end
            default: begin
            end
         endcase
      end

      if (ctl.exec) begin
         unique case (req_ff.command)
            CMD_PRG_READ: begin
               if (req_ff.address[15]) begin
                  mapped = {prg_win_ff[req_ff.address[14:13]], req_ff.address[12:0]};
               end
            end
            CMD_REG_WRITE: begin
               if (req_ff.address[15]) begin
                  unique case (req_ff.address[14:13])
                     RGN_BANK: begin
                        if (req_ff.address[0]) begin
                           bank_data_in[target_ff] = req_ff.write_data;
                        end else begin
                           target_in = req_ff.write_data[2:0];
                           swap_in   = req_ff.write_data[6];
                           invert_in = req_ff.write_data[7];
                        end
                     end
                     RGN_MIRROR: begin
                        if (!req_ff.address[0]) begin
                           mirror_in = req_ff.write_data[0];
                        end
                     end
                     RGN_IRQ_LATCH: begin
                        if (req_ff.address[0]) begin
                           counter_in = '0;
                        end else begin
                           reload_in = req_ff.write_data;
                        end
                     end
                     RGN_IRQ_ENABLE: begin
                        if (req_ff.address[0]) begin
                           irq_en_in = 1'b1;
                        end else begin
                           irq_en_in   = 1'b0;
                           irq_flag_in = 1'b0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            CMD_PATTERN_READ: begin
               if (pat_ram_ff) begin
                  mapped = {3'd0, req_ff.address};
               end else if (req_ff.address[15:13] == 3'd0) begin
                  mapped = {1'b0, pat_win_ff[req_ff.address[12:10]], req_ff.address[9:0]};
               end
            end
            CMD_SCANLINE: begin
               counter_in = (counter_ff == 8'd0) ? reload_ff : counter_ff - 8'd1;
               if (counter_in == 8'd0 && irq_en_ff) begin
                  irq_flag_in = 1'b1;
               end
            end
            CMD_IRQ_ACK: begin
               irq_flag_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (ctl.rebuild) begin
         for (int i = 0; i < 4; i++) begin
            pat_win_in[i]     = invert_ff ? high_set[i] : low_set[i];
            pat_win_in[i + 4] = invert_ff ? low_set[i] : high_set[i];
         end
         if (swap_ff) begin
            prg_win_in[2] = bank_data_ff[6][5:0];
            prg_win_in[0] = second_last(count_ff);
         end else begin
            prg_win_in[0] = bank_data_ff[6][5:0];
            prg_win_in[2] = second_last(count_ff);
         end
         prg_win_in[1] = bank_data_ff[7][5:0];
         prg_win_in[3] = last(count_ff);
      end

      rsp_in.mapped_address    = mapped;
      rsp_in.irq_pending       = irq_flag_in;
      rsp_in.mirror_horizontal = mirror_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= 6'd2;
         pat_ram_ff  <= 1'b0;
         target_ff   <= '0;
         swap_ff     <= 1'b0;
         invert_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            bank_data_ff[i] <= '0;
            pat_win_ff[i]   <= '0;
         end
         prg_win_ff[0] <= 6'd0;
         prg_win_ff[1] <= 6'd1;
         prg_win_ff[2] <= second_last(6'd2);
         prg_win_ff[3] <= last(6'd2);
         mirror_ff   <= 1'b0;
         reload_ff   <= '0;
         counter_ff  <= '0;
         irq_en_ff   <= 1'b0;
         irq_flag_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pat_ram_ff   <= pat_ram_in;
         target_ff    <= target_in;
         swap_ff      <= swap_in;
         invert_ff    <= invert_in;
         bank_data_ff <= bank_data_in;
         prg_win_ff   <= prg_win_in;
         pat_win_ff   <= pat_win_in;
         mirror_ff    <= mirror_in;
         reload_ff    <= reload_in;
         counter_ff   <= counter_in;
         irq_en_ff    <= irq_en_in;
         irq_flag_ff  <= irq_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_word;
      end
      if (ctl.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.bank_write = (req_ff.command == CMD_REG_WRITE) &&
                            (req_ff.address[15:13] == 3'b100) && req_ff.address[0];
   assign rsp_word = rsp_ff;

endmodule
`default_nettype wire

// ===== hdl/bmsi_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmsi_checker
// Port-level checks of the start/busy sequencing and the result strobe.
// ----------------------------------------------------------------------------
module bmsi_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe
);

   logic accept;
   assign accept = start && !busy;

   assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

   assert property (@(posedge clock) disable iff (reset) accept |=> busy && !rsp_strobe)
      else $error("busy not raised after accepted word");

   assert property (@(posedge clock) disable iff (reset) accept |-> ##2 rsp_strobe)
      else $error("result strobe missing two cycles after accept");

   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

endmodule

bind banked_mapper_with_scanline_irq_top bmsi_checker u_bmsi_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
`default_nettype wire
